### rtl/shdm_pkg.sv
// ----------------------------------------------------------------------------
// Spatial hash table package
// Word types, operation codes and hash constants shared by the spatial hash
// table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shdm_pkg;

  // Hash multipliers for the column and row coordinates
  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;

  // Operation codes carried in the input word
  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_LOAD       = 2'd1,
    OP_UNLOAD     = 2'd2,
    OP_UNLOAD_ALL = 2'd3
  } op_e;

  // Request word
  typedef struct packed {
    op_e                operation;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
  } in_word_t;

  // Response word
  typedef struct packed {
    logic               hit;
    logic [7:0]         slot;
    logic               evicted;
    logic signed [15:0] evicted_x;
    logic signed [15:0] evicted_y;
    logic [31:0]        seed;
    logic [8:0]         occupied_count;
  } out_word_t;

  // Request after hashing, as handed from the hash stage to the table stage
  typedef struct packed {
    op_e                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        h;
  } hash_word_t;

  // One table entry: valid flag and coordinate tag
  typedef struct packed {
    logic               valid;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } tag_entry_t;

endpackage

`default_nettype wire

### rtl/shdm_hash.sv
// ----------------------------------------------------------------------------
// Spatial hash coordinate hash stage
// Multiplies both coordinates by their hash constants into a register, then
// combines the products and folds the magnitude of the hash into a slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shdm_hash #(
  parameter int unsigned SlotBits = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire shdm_pkg::in_word_t       word_i,
  output logic                          vld_o,
  output shdm_pkg::hash_word_t          word_o,
  output logic [SlotBits-1:0]           slot_o
);

  logic               vld_q;
  shdm_pkg::op_e      op_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic [31:0]        hx_q;
  logic [31:0]        hy_q;
  logic [31:0]        hx_d;
  logic [31:0]        hy_d;
  logic [31:0]        h;
  logic [SlotBits-1:0] h_lo;

  // Sign-extended coordinate times its constant, wrapped to 32 bits
  always_comb begin
    hx_d = {{16{word_i.cell_x[15]}}, word_i.cell_x} * shdm_pkg::HASH_MUL_X;
    hy_d = {{16{word_i.cell_y[15]}}, word_i.cell_y} * shdm_pkg::HASH_MUL_Y;
  end

  // Stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Product and request registers
  always_ff @(posedge clk_i) begin
    if (en_i && vld_i) begin
      op_q <= word_i.operation;
      x_q  <= word_i.cell_x;
      y_q  <= word_i.cell_y;
      hx_q <= hx_d;
      hy_q <= hy_d;
    end
  end

  // Combine products; the slot is the low bits of the hash magnitude, which
  // for a negative hash are the low bits of its two's complement.
  always_comb begin
    h      = hx_q ^ hy_q;
    h_lo   = h[SlotBits-1:0];
    slot_o = h[31] ? (~h_lo + SlotBits'(1)) : h_lo;
    vld_o  = vld_q;
    word_o = '{op: op_q, x: x_q, y: y_q, h: h};
  end

endmodule

`default_nettype wire

### rtl/shdm_tag_ram.sv
// ----------------------------------------------------------------------------
// Spatial hash tag memory
// Simple dual-port memory holding the valid flag and tag of every slot, with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shdm_tag_ram #(
  parameter int unsigned Depth    = 256,
  parameter int unsigned AddrBits = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rd_en_i,
  input  wire logic [AddrBits-1:0]    rd_addr_i,
  output shdm_pkg::tag_entry_t        rd_data_o,
  input  wire logic                   we_i,
  input  wire logic [AddrBits-1:0]    wr_addr_i,
  input  wire shdm_pkg::tag_entry_t   wr_data_i
);

  shdm_pkg::tag_entry_t mem [Depth];
  shdm_pkg::tag_entry_t rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; a read of the address being written returns the
  // old contents.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### rtl/spatial_hash_direct_mapped_table.sv
// ----------------------------------------------------------------------------
// Direct-mapped spatial hash table
// Looks up, loads and unloads signed 2-D cell coordinates in a direct-mapped
// table indexed by a multiplicative coordinate hash, with a live entry count.
//
//   Channel   Direction  Handshake              Word
//   request   in         in_valid_i/in_ready_o  shdm_pkg::in_word_t
//   response  out        out_valid_o/out_ready_i shdm_pkg::out_word_t
//
// One word is accepted per cycle unless a response stall, a clearing pass
// or a pending unload-all holds requests off. Each word passes through the
// input, product, tag read and response registers to its response.
// After reset, and after each unload-all response, the tag memory is cleared
// one slot per cycle through its single write port, and no request is
// accepted during the pass. An unload-all also holds off further
// requests from its acceptance until that clearing pass begins.
// A stall on the response side freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spatial_hash_direct_mapped_table #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire shdm_pkg::in_word_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output shdm_pkg::out_word_t       out_data_o
);

  localparam int unsigned SlotBits  = $clog2(SLOTS);
  localparam int unsigned CountBits = $clog2(SLOTS + 1);

  logic                   adv;
  logic                   accept;
  logic                   exec;

  logic                   s1_vld_q;
  shdm_pkg::in_word_t     s1_q;

  logic                   h_vld;
  shdm_pkg::hash_word_t   h_word;
  logic [SlotBits-1:0]    h_slot;

  logic                   s3_vld_q;
  shdm_pkg::hash_word_t   s3_q;
  logic [SlotBits-1:0]    s3_slot_q;

  shdm_pkg::tag_entry_t   rd_data;
  logic                   fwd_q;
  shdm_pkg::tag_entry_t   fwd_data_q;
  shdm_pkg::tag_entry_t   entry;

  logic                   c_we;
  shdm_pkg::tag_entry_t   c_wdata;
  logic                   c_clear;
  logic                   hit;
  logic [CountBits-1:0]   cnt_q;
  logic [CountBits-1:0]   cnt_d;
  logic [16:0]            cnt_ext;
  logic [15:0]            slot_ext;
  shdm_pkg::out_word_t    res;

  logic                   sweep_q;
  logic [SlotBits-1:0]    sweep_cnt_q;
  logic                   blk_q;

  logic                   ram_we;
  logic [SlotBits-1:0]    ram_waddr;
  shdm_pkg::tag_entry_t   ram_wdata;

  logic                   out_vld_q;
  shdm_pkg::out_word_t    out_q;

  // Pipeline moves as one whenever the response register can take a word
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv && !sweep_q && !blk_q;
  assign accept     = in_valid_i && in_ready_o;
  assign exec       = adv && s3_vld_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
  end

  // Hash stage
  shdm_hash #(
    .SlotBits (SlotBits)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s1_vld_q),
    .word_i (s1_q),
    .vld_o  (h_vld),
    .word_o (h_word),
    .slot_o (h_slot)
  );

  // Table stage registers, alongside the tag read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= h_vld;
    end
  end

  // The word ahead writes its slot at the same edge as this read, so its
  // write data is captured to stand in for the stale read.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q       <= h_word;
      s3_slot_q  <= h_slot;
      fwd_q      <= c_we && (s3_slot_q == h_slot);
      fwd_data_q <= c_wdata;
    end
  end

  shdm_tag_ram #(
    .Depth    (SLOTS),
    .AddrBits (SlotBits)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .rd_en_i   (adv && h_vld),
    .rd_addr_i (h_slot),
    .rd_data_o (rd_data),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata)
  );

  // Compare the tag and work out the table update and response
  always_comb begin
    entry    = fwd_q ? fwd_data_q : rd_data;
    hit      = entry.valid && (entry.x == s3_q.x) && (entry.y == s3_q.y);
    c_we     = 1'b0;
    c_wdata  = '{valid: 1'b1, x: s3_q.x, y: s3_q.y};
    c_clear  = 1'b0;
    cnt_d    = cnt_q;
    slot_ext = 16'(s3_slot_q);
    res      = '0;
    res.hit  = hit;
    res.slot = slot_ext[7:0];
    res.seed = s3_q.h;
    case (s3_q.op)
      shdm_pkg::OP_LOAD: begin
        if (!hit) begin
          c_we          = exec;
          res.evicted   = entry.valid;
          res.evicted_x = entry.valid ? entry.x : '0;
          res.evicted_y = entry.valid ? entry.y : '0;
          if (!entry.valid) begin
            cnt_d = cnt_q + CountBits'(1);
          end
        end
      end
      shdm_pkg::OP_UNLOAD: begin
        if (hit) begin
          c_we          = exec;
          c_wdata.valid = 1'b0;
          cnt_d         = cnt_q - CountBits'(1);
        end
      end
      shdm_pkg::OP_UNLOAD_ALL: begin
        c_clear = exec;
        cnt_d   = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
    cnt_ext            = 17'(cnt_d);
    res.occupied_count = cnt_ext[8:0];
  end

  // Memory write port: clearing pass or table update
  always_comb begin
    ram_we    = sweep_q || c_we;
    ram_waddr = sweep_q ? sweep_cnt_q : s3_slot_q;
    ram_wdata = sweep_q ? '0 : c_wdata;
  end

  // Clearing pass after reset and after unload-all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
    end else if (c_clear) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
    end else if (sweep_q) begin
      if (sweep_cnt_q == SlotBits'(SLOTS - 1)) begin
        sweep_q <= 1'b0;
      end
      sweep_cnt_q <= sweep_cnt_q + SlotBits'(1);
    end
  end

  // Hold off requests from an unload-all until its clearing pass starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= 1'b0;
    end else if (c_clear) begin
      blk_q <= 1'b0;
    end else if (accept && (in_data_i.operation == shdm_pkg::OP_UNLOAD_ALL)) begin
      blk_q <= 1'b1;
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (exec) begin
      cnt_q <= cnt_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // No request enters while the memory is being cleared
  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  // The count never exceeds the table size
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountBits'(SLOTS))
    else $error("entry count above table size");

  // An unload-all empties the count and starts the clearing pass
  a_clear_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_clear |=> (cnt_q == '0) && sweep_q)
    else $error("unload-all did not clear the table");

  // Forwarded data only follows a table update
  a_fwd_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(c_we))
    else $error("forward without a preceding write");

  // An evicting load never reports a hit
  a_evict_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.evicted) |-> !out_q.hit)
    else $error("eviction reported together with a hit");

endmodule

`default_nettype wire
